### hdl/trilinear_gradient_transpose_accumulate_unit_defines.svh
// assertion macros for the trilinear gradient transpose accumulate unit
// no dependencies; taken in by `include where assertions are written
`ifndef TRILINEAR_GRADIENT_TRANSPOSE_ACCUMULATE_UNIT_DEFINES_SVH
`define TRILINEAR_GRADIENT_TRANSPOSE_ACCUMULATE_UNIT_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication
`define TGTA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tgta: same-cycle check failed");

// next-cycle implication
`define TGTA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tgta: next-cycle check failed");

`else

`define TGTA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define TGTA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### hdl/tgta_pkg.sv
// package of the trilinear gradient transpose accumulate unit
// types, register codes and saturating fixed-point helpers; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tgta_pkg;

  // fixed-point format
  localparam int unsigned FracBits = 16;
  localparam int unsigned DataW    = 32;
  localparam int unsigned WeightW  = 17;
  localparam int unsigned NodeW    = 64;
  localparam int unsigned CfgIdxW  = 2;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgInvX = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgInvY = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgInvZ = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgGain = 2'd3;

  typedef logic signed [DataW-1:0] q_t;
  typedef logic [DataW-1:0]        uq_t;
  typedef logic [WeightW-1:0]      w_t;

  // 1.0 in the register format
  localparam uq_t OneQ = uq_t'(1) << FracBits;

  localparam q_t QMax = 32'h7FFF_FFFF;
  localparam q_t QMin = 32'h8000_0000;

  // per-axis derivative scales
  typedef struct packed {
    uq_t x;
    uq_t y;
    uq_t z;
  } scale_t;

  // edge terms and carried operands between front and back halves
  typedef struct packed {
    q_t [3:0] ex;    // y0z0, y0z1, y1z0, y1z1
    q_t [3:0] ey;    // x0z0, x0z1, x1z0, x1z1
    w_t       wx;
    w_t       wy;
    q_t [7:0] node;  // index bits are x y z
  } edges_t;

  // saturating add
  function automatic q_t sat_add(input q_t a, input q_t b);
    logic [DataW:0] s;
    s = {a[DataW-1], a} + {b[DataW-1], b};
    if (s[DataW] != s[DataW-1]) begin
      return s[DataW] ? QMin : QMax;
    end
    return q_t'(s[DataW-1:0]);
  endfunction

  // saturating subtract
  function automatic q_t sat_sub(input q_t a, input q_t b);
    logic [DataW:0] s;
    s = {a[DataW-1], a} - {b[DataW-1], b};
    if (s[DataW] != s[DataW-1]) begin
      return s[DataW] ? QMin : QMax;
    end
    return q_t'(s[DataW-1:0]);
  endfunction

  // signed times unsigned, floor shift, saturate to 32 bits
  function automatic q_t mul_q(input q_t a, input uq_t b);
    logic signed [2*DataW:0] p;
    logic signed [2*DataW:0] sh;
    p  = a * $signed({1'b0, b});
    sh = p >>> FracBits;
    if (!sh[2*DataW] && (|sh[2*DataW-1:DataW-1])) begin
      return QMax;
    end
    if (sh[2*DataW] && !(&sh[2*DataW-1:DataW-1])) begin
      return QMin;
    end
    return q_t'(sh[DataW-1:0]);
  endfunction

  // gain times inverse spacing, unsigned saturate
  function automatic uq_t scale_of(input uq_t g, input uq_t s);
    logic [2*DataW-1:0] p;
    logic [2*DataW-1:0] sh;
    p  = {{DataW{1'b0}}, g} * {{DataW{1'b0}}, s};
    sh = p >> FracBits;
    if (|sh[2*DataW-1:DataW]) begin
      return '1;
    end
    return sh[DataW-1:0];
  endfunction

endpackage

`default_nettype wire

### hdl/trilinear_gradient_transpose_accumulate_unit.sv
// Trilinear gradient transpose accumulate unit, top level.
// Input channel: in_valid_i / in_ready_o; one beat carries three cell-centre
//   derivatives, three interpolation weights and eight packed nodal values.
// Output channel: out_valid_o / out_ready_i; one beat carries the eight
//   accumulated nodal values, saturated Q16.16.
// Configuration channel: cfg_valid_i / cfg_ready_o with cfg_index_i and
//   cfg_data_i; always ready, write only while no beat is in flight.
// Throughput: one beat per cycle while the receiver takes output beats; the
//   seven-stage pipeline (scale capture, derivative scaling, weight products,
//   edge terms, spread products, x spread, y spread) has a chain of stage enables
//   that lets a new beat enter whenever any stage ahead has room.
// Reset clears all valid bits and sets every configuration register to 1.0.
// When the receiver stalls the output register holds its beat, the stages
//   behind it fill up, and in_ready_o drops only once all seven are full.
// Depends on tgta_pkg, tgta_cfg, tgta_front, tgta_back and the defines header.
`timescale 1ns / 1ps
`default_nettype none

`include "trilinear_gradient_transpose_accumulate_unit_defines.svh"

module trilinear_gradient_transpose_accumulate_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write channel
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [tgta_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [tgta_pkg::DataW-1:0]    cfg_data_i,
  // input channel
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic signed [31:0]            deriv_x_i,
  input  wire logic signed [31:0]            deriv_y_i,
  input  wire logic signed [31:0]            deriv_z_i,
  input  wire logic [16:0]                   weight_x_i,
  input  wire logic [16:0]                   weight_y_i,
  input  wire logic [16:0]                   weight_z_i,
  input  wire logic [63:0]                   nodes_a_i,
  input  wire logic [63:0]                   nodes_b_i,
  input  wire logic [63:0]                   nodes_c_i,
  input  wire logic [63:0]                   nodes_d_i,
  // output channel
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [31:0]                 node_000_o,
  output logic signed [31:0]                 node_001_o,
  output logic signed [31:0]                 node_010_o,
  output logic signed [31:0]                 node_011_o,
  output logic signed [31:0]                 node_100_o,
  output logic signed [31:0]                 node_101_o,
  output logic signed [31:0]                 node_110_o,
  output logic signed [31:0]                 node_111_o
);

  tgta_pkg::scale_t        scale;
  tgta_pkg::edges_t        edges;
  logic                    front_valid;
  logic                    back_ready;
  tgta_pkg::q_t [7:0]      node;

  // registers and scales
  tgta_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .scale_o     (scale)
  );

  // derivative scaling and edge terms
  tgta_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .deriv_x_i   (deriv_x_i),
    .deriv_y_i   (deriv_y_i),
    .deriv_z_i   (deriv_z_i),
    .weight_x_i  (weight_x_i),
    .weight_y_i  (weight_y_i),
    .weight_z_i  (weight_z_i),
    .nodes_a_i   (nodes_a_i),
    .nodes_b_i   (nodes_b_i),
    .nodes_c_i   (nodes_c_i),
    .nodes_d_i   (nodes_d_i),
    .scale_i     (scale),
    .out_valid_o (front_valid),
    .out_ready_i (back_ready),
    .out_o       (edges)
  );

  // spread into the nodal values
  tgta_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_valid),
    .in_ready_o  (back_ready),
    .in_i        (edges),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .node_o      (node)
  );

  // corner outputs, index bits are x y z
  assign node_000_o = node[0];
  assign node_001_o = node[1];
  assign node_010_o = node[2];
  assign node_011_o = node[3];
  assign node_100_o = node[4];
  assign node_101_o = node[5];
  assign node_110_o = node[6];
  assign node_111_o = node[7];

  // back-pressure only ever starts at a stalled output beat
  `TGTA_ASSERT_IMPL(a_stall_from_output, clk_i, rst_ni, !in_ready_o,
                    out_valid_o && !out_ready_i)

  // the back half refuses a beat only while the output is stalled
  `TGTA_ASSERT_IMPL(a_back_stall, clk_i, rst_ni, front_valid && !back_ready,
                    out_valid_o && !out_ready_i)

  // a zero gain zeroes every axis scale
  `TGTA_ASSERT_NEXT(a_zero_gain, clk_i, rst_ni,
                    cfg_valid_i && cfg_ready_o && (cfg_index_i == tgta_pkg::CfgGain)
                      && (cfg_data_i == '0),
                    (scale.x == '0) && (scale.y == '0) && (scale.z == '0))

endmodule

`default_nettype wire

### hdl/tgta_cfg.sv
// configuration registers and per-axis derivative scale
// depends on tgta_pkg
`timescale 1ns / 1ps
`default_nettype none

module tgta_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [tgta_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [tgta_pkg::DataW-1:0]    cfg_data_i,
  output tgta_pkg::scale_t                   scale_o
);

  tgta_pkg::uq_t inv_x_q, inv_y_q, inv_z_q, gain_q;

  // writes are always taken
  assign cfg_ready_o = 1'b1;

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_x_q <= tgta_pkg::OneQ;
      inv_y_q <= tgta_pkg::OneQ;
      inv_z_q <= tgta_pkg::OneQ;
      gain_q  <= tgta_pkg::OneQ;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tgta_pkg::CfgInvX: inv_x_q <= cfg_data_i;
        tgta_pkg::CfgInvY: inv_y_q <= cfg_data_i;
        tgta_pkg::CfgInvZ: inv_z_q <= cfg_data_i;
        tgta_pkg::CfgGain: gain_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // scales, captured by the first pipeline stage
  assign scale_o.x = tgta_pkg::scale_of(gain_q, inv_x_q);
  assign scale_o.y = tgta_pkg::scale_of(gain_q, inv_y_q);
  assign scale_o.z = tgta_pkg::scale_of(gain_q, inv_z_q);

endmodule

`default_nettype wire

### hdl/tgta_front.sv
// front half: derivative scaling, last-interpolation split and edge terms
// four register stages; depends on tgta_pkg
`timescale 1ns / 1ps
`default_nettype none

module tgta_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire tgta_pkg::q_t                deriv_x_i,
  input  wire tgta_pkg::q_t                deriv_y_i,
  input  wire tgta_pkg::q_t                deriv_z_i,
  input  wire tgta_pkg::w_t                weight_x_i,
  input  wire tgta_pkg::w_t                weight_y_i,
  input  wire tgta_pkg::w_t                weight_z_i,
  input  wire logic [tgta_pkg::NodeW-1:0]  nodes_a_i,
  input  wire logic [tgta_pkg::NodeW-1:0]  nodes_b_i,
  input  wire logic [tgta_pkg::NodeW-1:0]  nodes_c_i,
  input  wire logic [tgta_pkg::NodeW-1:0]  nodes_d_i,
  input  wire tgta_pkg::scale_t            scale_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output tgta_pkg::edges_t                 out_o
);

  // stage valids and enables
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  // stage 1: captured operands
  tgta_pkg::q_t  [2:0] der1_q;
  tgta_pkg::uq_t [2:0] scl1_q;
  tgta_pkg::w_t  [2:0] w1_q;
  tgta_pkg::q_t  [7:0] node1_q;
  tgta_pkg::q_t  [7:0] node_in;

  // stage 2: scaled derivatives
  tgta_pkg::q_t  [2:0] d2_q;
  tgta_pkg::w_t  [2:0] w2_q;
  tgta_pkg::q_t  [7:0] node2_q;

  // stage 3: weighted derivatives
  tgta_pkg::q_t  [2:0] d3_q;
  tgta_pkg::q_t  [2:0] p3_q;
  tgta_pkg::w_t        wx3_q, wy3_q;
  tgta_pkg::q_t  [7:0] node3_q;

  // stage 4: edge terms
  tgta_pkg::edges_t    e4_d, e4_q;
  tgta_pkg::q_t        dxz0, dyz0, dzy0;

  // a stage moves when it is empty or its successor moves
  assign en4 = !v4_q || out_ready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  // unpack the nodal pairs, low word first
  assign node_in[0] = tgta_pkg::q_t'(nodes_a_i[31:0]);
  assign node_in[1] = tgta_pkg::q_t'(nodes_a_i[63:32]);
  assign node_in[2] = tgta_pkg::q_t'(nodes_b_i[31:0]);
  assign node_in[3] = tgta_pkg::q_t'(nodes_b_i[63:32]);
  assign node_in[4] = tgta_pkg::q_t'(nodes_c_i[31:0]);
  assign node_in[5] = tgta_pkg::q_t'(nodes_c_i[63:32]);
  assign node_in[6] = tgta_pkg::q_t'(nodes_d_i[31:0]);
  assign node_in[7] = tgta_pkg::q_t'(nodes_d_i[63:32]);

  // undo the last interpolation and the differentiation
  always_comb begin
    dxz0 = tgta_pkg::sat_sub(d3_q[0], p3_q[0]);
    dyz0 = tgta_pkg::sat_sub(d3_q[1], p3_q[1]);
    dzy0 = tgta_pkg::sat_sub(d3_q[2], p3_q[2]);
    e4_d.ey[0] = tgta_pkg::sat_sub('0, dxz0);
    e4_d.ey[1] = tgta_pkg::sat_sub('0, p3_q[0]);
    e4_d.ey[2] = dxz0;
    e4_d.ey[3] = p3_q[0];
    e4_d.ex[0] = tgta_pkg::sat_sub(tgta_pkg::sat_sub('0, dyz0), dzy0);
    e4_d.ex[1] = tgta_pkg::sat_sub(dzy0, p3_q[1]);
    e4_d.ex[2] = tgta_pkg::sat_sub(dyz0, p3_q[2]);
    e4_d.ex[3] = tgta_pkg::sat_add(p3_q[1], p3_q[2]);
    e4_d.wx    = wx3_q;
    e4_d.wy    = wy3_q;
    e4_d.node  = node3_q;
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      der1_q  <= {deriv_z_i, deriv_y_i, deriv_x_i};
      scl1_q  <= {scale_i.z, scale_i.y, scale_i.x};
      w1_q    <= {weight_z_i, weight_y_i, weight_x_i};
      node1_q <= node_in;
    end
    if (en2 && v1_q) begin
      for (int k = 0; k < 3; k++) begin
        d2_q[k] <= tgta_pkg::mul_q(der1_q[k], scl1_q[k]);
      end
      w2_q    <= w1_q;
      node2_q <= node1_q;
    end
    if (en3 && v2_q) begin
      p3_q[0] <= tgta_pkg::mul_q(d2_q[0], tgta_pkg::uq_t'(w2_q[2]));
      p3_q[1] <= tgta_pkg::mul_q(d2_q[1], tgta_pkg::uq_t'(w2_q[2]));
      p3_q[2] <= tgta_pkg::mul_q(d2_q[2], tgta_pkg::uq_t'(w2_q[1]));
      d3_q    <= d2_q;
      wx3_q   <= w2_q[0];
      wy3_q   <= w2_q[1];
      node3_q <= node2_q;
    end
    if (en4 && v3_q) begin
      e4_q <= e4_d;
    end
  end

  assign out_valid_o = v4_q;
  assign out_o       = e4_q;

endmodule

`default_nettype wire

### hdl/tgta_back.sv
// back half: spread of edge terms along x and y into the nodal values
// three register stages, the last one is the output register; depends on tgta_pkg
`timescale 1ns / 1ps
`default_nettype none

module tgta_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire tgta_pkg::edges_t  in_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output tgta_pkg::q_t [7:0]     node_o
);

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  // stage 1: weighted edge terms
  tgta_pkg::edges_t     e1_q;
  tgta_pkg::q_t [7:0]   tw1_q;

  // stage 2: nodes after the x spread
  tgta_pkg::q_t [7:0]   node2_d, node2_q;
  tgta_pkg::q_t [3:0]   ey2_q, twy2_q;

  // stage 3: nodes after the y spread
  tgta_pkg::q_t [7:0]   node3_d, node3_q;

  assign en3 = !v3_q || out_ready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  // x spread: edge i feeds corner i (x0) and corner i+4 (x1)
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      node2_d[i + 4] = tgta_pkg::sat_add(e1_q.node[i + 4], tw1_q[i]);
      node2_d[i]     = tgta_pkg::sat_sub(tgta_pkg::sat_add(e1_q.node[i], e1_q.ex[i]),
                                         tw1_q[i]);
    end
  end

  // y spread: edge i feeds corners with y0 and y1 at the same x and z
  always_comb begin
    node3_d = node2_q;
    for (int i = 0; i < 4; i++) begin
      node3_d[(i / 2) * 4 + (i % 2) + 2] =
        tgta_pkg::sat_add(node2_q[(i / 2) * 4 + (i % 2) + 2], twy2_q[i]);
      node3_d[(i / 2) * 4 + (i % 2)] =
        tgta_pkg::sat_sub(tgta_pkg::sat_add(node2_q[(i / 2) * 4 + (i % 2)], ey2_q[i]),
                          twy2_q[i]);
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      e1_q <= in_i;
      for (int i = 0; i < 4; i++) begin
        tw1_q[i]     <= tgta_pkg::mul_q(in_i.ex[i], tgta_pkg::uq_t'(in_i.wx));
        tw1_q[i + 4] <= tgta_pkg::mul_q(in_i.ey[i], tgta_pkg::uq_t'(in_i.wy));
      end
    end
    if (en2 && v1_q) begin
      node2_q <= node2_d;
      ey2_q   <= e1_q.ey;
      twy2_q  <= tw1_q[7:4];
    end
    if (en3 && v2_q) begin
      node3_q <= node3_d;
    end
  end

  assign out_valid_o = v3_q;
  assign node_o      = node3_q;

endmodule

`default_nettype wire
